[src/tcla_pkg.sv]
`timescale 1ns / 1ps

package tcla_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_DS_MINIMUM    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DS_MIDDLE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CYCLE_MINIMUM = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CYCLE_MIDDLE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CYCLE_MAXIMUM = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOPE_LOWER   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOPE_UPPER   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_CYCLE = 3'd7;

    // Register reset values.
    localparam logic [11:0] RST_DS_MINIMUM    = 12'd0;
    localparam logic [11:0] RST_DS_MIDDLE     = 12'd922;
    localparam logic [11:0] RST_CYCLE_MINIMUM = 12'd640;
    localparam logic [11:0] RST_CYCLE_MIDDLE  = 12'd1440;
    localparam logic [11:0] RST_CYCLE_MAXIMUM = 12'd2880;
    localparam logic [15:0] RST_SLOPE_LOWER   = 16'd4096;
    localparam logic [15:0] RST_SLOPE_UPPER   = 16'd4096;
    localparam logic [11:0] RST_INITIAL_CYCLE = 12'd1440;

    // Lengths are in 1/16 s: 4 s, 8 s, 6 s and 9 s.
    localparam logic [16:0] KNEE_ONE    = 17'd64;
    localparam logic [16:0] KNEE_TWO    = 17'd128;
    localparam logic [14:0] COMP_OFS_1  = 15'd32;
    localparam logic [14:0] COMP_OFS_2  = 15'd64;
    localparam logic signed [13:0] SLEW_NORMAL = 14'sd96;
    localparam logic signed [13:0] SLEW_WIDE   = 14'sd144;
    localparam logic [12:0] RAW_MAX     = 13'd8191;

    // Averaging weights in Q10 (0.45, 0.33, 0.22), sum 1024.
    localparam logic [9:0]  W_NEW   = 10'd461;
    localparam logic [9:0]  W_OLD1  = 10'd338;
    localparam logic [9:0]  W_OLD2  = 10'd225;
    localparam logic [23:0] AVG_RND = 24'd512;

    // Half-up rounding of the Q4.12 segment term.
    localparam logic signed [29:0] SEG_RND = 30'sd2048;

    typedef struct packed {
        logic [11:0] ds_minimum;
        logic [11:0] ds_middle;
        logic [11:0] cycle_minimum;
        logic [11:0] cycle_middle;
        logic [11:0] cycle_maximum;
        logic [15:0] slope_lower;
        logic [15:0] slope_upper;
        logic [11:0] initial_cycle;
    } t_cfg;

    typedef struct packed {
        logic [11:0] current_length;
        logic [11:0] previous_length;
        logic [12:0] raw_history_one;
        logic [12:0] raw_history_two;
    } t_hist;

endpackage

[src/tcla_target.sv]
`timescale 1ns / 1ps

module tcla_target (
    input  logic [11:0]         i_max_saturation,
    input  tcla_pkg::t_cfg      i_cfg,
    output logic signed [18:0]  o_target
);

    logic               sel_lower;
    logic signed [12:0] diff;
    logic [15:0]        slope;
    logic [11:0]        base;
    logic signed [29:0] prod;
    logic signed [29:0] prod_rnd;
    logic signed [17:0] term;

    // Pick the segment: lower one up to and including the middle knee.
    always_comb begin
        sel_lower = (i_max_saturation <= i_cfg.ds_middle);
        if (sel_lower) begin
            diff  = $signed({1'b0, i_max_saturation}) - $signed({1'b0, i_cfg.ds_minimum});
            slope = i_cfg.slope_lower;
            base  = i_cfg.cycle_minimum;
        end else begin
            diff  = $signed({1'b0, i_max_saturation}) - $signed({1'b0, i_cfg.ds_middle});
            slope = i_cfg.slope_upper;
            base  = i_cfg.cycle_middle;
        end
    end

    // Signed offset times Q4.12 slope, rounded half up by a floor shift.
    assign prod     = $signed({{17{diff[12]}}, diff}) * $signed({14'd0, slope});
    assign prod_rnd = prod + tcla_pkg::SEG_RND;
    assign term     = prod_rnd[29:12];

    assign o_target = $signed({7'd0, base}) + $signed({term[17], term});

endmodule

[src/tcla_update.sv]
`timescale 1ns / 1ps

module tcla_update (
    input  logic signed [18:0]  i_target,
    input  tcla_pkg::t_hist     i_hist,
    input  logic [11:0]         i_cycle_minimum,
    input  logic [11:0]         i_cycle_maximum,
    output logic [11:0]         o_next_length,
    output logic                o_step_limited,
    output logic [12:0]         o_raw
);

    logic signed [19:0] gap;
    logic               up;
    logic [16:0]        mag;
    logic [14:0]        comp;
    logic signed [16:0] raw_s;
    logic [23:0]        wsum;
    logic [12:0]        avg;
    logic signed [13:0] d;
    logic signed [12:0] last_step;
    logic               wide;
    logic signed [14:0] cur_s;
    logic signed [14:0] next_s;
    logic               limited;

    // Compress the gap between target and current length.
    always_comb begin
        gap = $signed({i_target[18], i_target}) - $signed({8'd0, i_hist.current_length});
        up  = !gap[19];
        mag = up ? gap[16:0] : 17'(-gap);
        if (mag <= tcla_pkg::KNEE_ONE) begin
            comp = mag[14:0];
        end else if (mag <= tcla_pkg::KNEE_TWO) begin
            comp = {1'b0, mag[14:1]} + tcla_pkg::COMP_OFS_1;
        end else begin
            comp = mag[16:2] + tcla_pkg::COMP_OFS_2;
        end
        if (up) begin
            raw_s = $signed({5'd0, i_hist.current_length}) + $signed({2'd0, comp});
        end else begin
            raw_s = $signed({5'd0, i_hist.current_length}) - $signed({2'd0, comp});
        end
        if (raw_s < 0) begin
            o_raw = 13'd0;
        end else if (raw_s > $signed({4'd0, tcla_pkg::RAW_MAX})) begin
            o_raw = tcla_pkg::RAW_MAX;
        end else begin
            o_raw = raw_s[12:0];
        end
    end

    // Weighted average with the two previous raw lengths, rounded half up.
    assign wsum = {11'd0, o_raw} * {14'd0, tcla_pkg::W_NEW}
                + {11'd0, i_hist.raw_history_one} * {14'd0, tcla_pkg::W_OLD1}
                + {11'd0, i_hist.raw_history_two} * {14'd0, tcla_pkg::W_OLD2}
                + tcla_pkg::AVG_RND;
    assign avg  = wsum[22:10];

    // Slew limit, widened after two large steps in the same direction.
    always_comb begin
        d         = $signed({1'b0, avg}) - $signed({2'd0, i_hist.current_length});
        last_step = $signed({1'b0, i_hist.current_length})
                  - $signed({1'b0, i_hist.previous_length});
        cur_s     = $signed({3'd0, i_hist.current_length});
        wide      = (d >= tcla_pkg::SLEW_NORMAL && last_step >= 13'sd96)
                 || (d <= -tcla_pkg::SLEW_NORMAL && last_step <= -13'sd96);
        if (wide) begin
            if (d <= tcla_pkg::SLEW_WIDE && d >= -tcla_pkg::SLEW_WIDE) begin
                next_s  = $signed({2'd0, avg});
                limited = 1'b0;
            end else begin
                next_s  = d[13] ? cur_s - 15'sd144 : cur_s + 15'sd144;
                limited = 1'b1;
            end
        end else begin
            if (d <= tcla_pkg::SLEW_NORMAL && d >= -tcla_pkg::SLEW_NORMAL) begin
                next_s  = $signed({2'd0, avg});
                limited = 1'b0;
            end else begin
                next_s  = d[13] ? cur_s - 15'sd96 : cur_s + 15'sd96;
                limited = 1'b1;
            end
        end
    end

    // Clamp to the cycle limits; the maximum is tested first.
    always_comb begin
        if (next_s > $signed({3'd0, i_cycle_maximum})) begin
            o_next_length = i_cycle_maximum;
        end else if (next_s < $signed({3'd0, i_cycle_minimum})) begin
            o_next_length = i_cycle_minimum;
        end else begin
            o_next_length = next_s[11:0];
        end
    end

    assign o_step_limited = limited;

endmodule

[src/traffic_cycle_length_adapter_core.sv]
`timescale 1ns / 1ps

// Adaptive signal cycle length. Each input word carries the largest degree
// of saturation seen in one signal cycle; each output word carries the new
// cycle length and a flag that tells whether the slew limit cut the change.
// Both channels use valid and ready. Eight registers are written through the
// plain write port; the user must write them only while the block is idle,
// which the block itself does not enforce. A write to the initial cycle
// register also reloads all history. An accepted word has its target length
// registered in the target stage, and its result is loaded into the output
// register when the output is free. Throughput is one word per cycle while
// the receiver does not stall; the history registers are updated as each
// result is loaded, which closes the feedback. Reset loads the register
// defaults, sets all history to the initial cycle length and empties the
// pipeline. When the receiver stalls, the result holds in the output
// register and one more word waits in the target stage; after that, input
// ready drops until the output is taken.
module traffic_cycle_length_adapter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [11:0]                         i_max_saturation,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [11:0]                         o_next_length,
    output logic                                o_step_limited,
    input  logic                                i_cfg_we,
    input  logic [tcla_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tcla_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    tcla_pkg::t_cfg     r_cfg;
    tcla_pkg::t_hist    r_hist;
    logic               r_a_valid;
    logic signed [18:0] r_target;
    logic               r_out_valid;
    logic [11:0]        r_next_length;
    logic               r_step_limited;

    logic signed [18:0] n_target;
    logic [11:0]        n_next_length;
    logic               n_step_limited;
    logic [12:0]        n_raw;
    logic               a_take;
    logic               b_adv;
    logic               b_load;
    logic               init_write;

    // Handshake control for the two stages.
    assign b_adv      = !r_out_valid || i_ready;
    assign b_load     = r_a_valid && b_adv;
    assign o_ready    = !r_a_valid || b_adv;
    assign a_take     = i_valid && o_ready;
    assign init_write = i_cfg_we && (i_cfg_addr == tcla_pkg::REG_INITIAL_CYCLE);

    tcla_target u_target (
        .i_max_saturation (i_max_saturation),
        .i_cfg            (r_cfg),
        .o_target         (n_target)
    );

    tcla_update u_update (
        .i_target        (r_target),
        .i_hist          (r_hist),
        .i_cycle_minimum (r_cfg.cycle_minimum),
        .i_cycle_maximum (r_cfg.cycle_maximum),
        .o_next_length   (n_next_length),
        .o_step_limited  (n_step_limited),
        .o_raw           (n_raw)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ds_minimum    <= tcla_pkg::RST_DS_MINIMUM;
            r_cfg.ds_middle     <= tcla_pkg::RST_DS_MIDDLE;
            r_cfg.cycle_minimum <= tcla_pkg::RST_CYCLE_MINIMUM;
            r_cfg.cycle_middle  <= tcla_pkg::RST_CYCLE_MIDDLE;
            r_cfg.cycle_maximum <= tcla_pkg::RST_CYCLE_MAXIMUM;
            r_cfg.slope_lower   <= tcla_pkg::RST_SLOPE_LOWER;
            r_cfg.slope_upper   <= tcla_pkg::RST_SLOPE_UPPER;
            r_cfg.initial_cycle <= tcla_pkg::RST_INITIAL_CYCLE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tcla_pkg::REG_DS_MINIMUM:    r_cfg.ds_minimum    <= i_cfg_data[11:0];
                tcla_pkg::REG_DS_MIDDLE:     r_cfg.ds_middle     <= i_cfg_data[11:0];
                tcla_pkg::REG_CYCLE_MINIMUM: r_cfg.cycle_minimum <= i_cfg_data[11:0];
                tcla_pkg::REG_CYCLE_MIDDLE:  r_cfg.cycle_middle  <= i_cfg_data[11:0];
                tcla_pkg::REG_CYCLE_MAXIMUM: r_cfg.cycle_maximum <= i_cfg_data[11:0];
                tcla_pkg::REG_SLOPE_LOWER:   r_cfg.slope_lower   <= i_cfg_data;
                tcla_pkg::REG_SLOPE_UPPER:   r_cfg.slope_upper   <= i_cfg_data;
                tcla_pkg::REG_INITIAL_CYCLE: r_cfg.initial_cycle <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // History: reloaded on reset or an initial cycle write, shifted per result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist.current_length  <= tcla_pkg::RST_INITIAL_CYCLE;
            r_hist.previous_length <= tcla_pkg::RST_INITIAL_CYCLE;
            r_hist.raw_history_one <= {1'b0, tcla_pkg::RST_INITIAL_CYCLE};
            r_hist.raw_history_two <= {1'b0, tcla_pkg::RST_INITIAL_CYCLE};
        end else if (init_write) begin
            r_hist.current_length  <= i_cfg_data[11:0];
            r_hist.previous_length <= i_cfg_data[11:0];
            r_hist.raw_history_one <= {1'b0, i_cfg_data[11:0]};
            r_hist.raw_history_two <= {1'b0, i_cfg_data[11:0]};
        end else if (b_load) begin
            r_hist.current_length  <= n_next_length;
            r_hist.previous_length <= r_hist.current_length;
            r_hist.raw_history_one <= n_raw;
            r_hist.raw_history_two <= r_hist.raw_history_one;
        end
    end

    // Target stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_take) begin
            r_a_valid <= 1'b1;
        end else if (b_load) begin
            r_a_valid <= 1'b0;
        end
    end

    // Target stage payload.
    always_ff @(posedge i_clk) begin
        if (a_take) begin
            r_target <= n_target;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv) begin
            r_out_valid <= r_a_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_next_length  <= n_next_length;
            r_step_limited <= n_step_limited;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_next_length  = r_next_length;
    assign o_step_limited = r_step_limited;

    // A waiting target word is kept while the output is stalled.
    a_target_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_out_valid && !i_ready |=> r_a_valid)
        else $error("target word lost during output stall");

    // Input ready drops only with both stages full and the output stalled.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_a_valid && r_out_valid && !i_ready)
        else $error("input ready low without a full pipeline");

    // The current length follows the delivered result.
    a_cur_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_load && !init_write |=> r_hist.current_length == o_next_length)
        else $error("current length differs from the loaded result");

    // The previous length takes the old current length.
    a_prev_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_load && !init_write |=> r_hist.previous_length == $past(r_hist.current_length))
        else $error("previous length did not shift");

endmodule
